/* hw/rtl/rka_pkg.sv */
`default_nettype none
package rka_pkg;

	localparam int SAMPLE_W     = 32;
	localparam int RANK_W       = 6;
	localparam int CNT_W        = 7;
	localparam int CAPACITY_DEF = 64;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [RANK_W-1:0]          rank_t;
	typedef logic [CNT_W-1:0]           cnt_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic wr;
		cnt_t wr_idx;
		logic rank;
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/rka_cell.sv */
`default_nettype none
module rka_cell #(
	parameter int IDX = 0
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  rka_pkg::cell_ctl_t     ctl,
	input  rka_pkg::sample_t       sample,
	input  rka_pkg::sample_t       trav_in,
	input  wire                    trav_vld_in,
	input  rka_pkg::rank_t         cnt_in,
	output rka_pkg::sample_t       trav_out,
	output logic                   trav_vld_out,
	output rka_pkg::rank_t         cnt_out
);

	rka_pkg::sample_t own_q;
	rka_pkg::sample_t trav_q;
	rka_pkg::rank_t   cnt_q;
	logic             own_vld_q;
	logic             trav_vld_q;
	logic             wr_me;
	logic             smaller;

	assign wr_me   = ctl.wr && (ctl.wr_idx == rka_pkg::CNT_W'(IDX));
	assign smaller = trav_vld_in && own_vld_q && (trav_in < own_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_vld_q  <= 1'b0;
			trav_vld_q <= 1'b0;
		end else if (ctl.clear) begin
			own_vld_q  <= 1'b0;
			trav_vld_q <= 1'b0;
		end else if (wr_me) begin
			own_vld_q  <= 1'b1;
			trav_vld_q <= 1'b1;
		end else if (ctl.rank) begin
			trav_vld_q <= trav_vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_me) begin
			own_q  <= sample;
			trav_q <= sample;
			cnt_q  <= '0;
		end else if (ctl.rank) begin
			trav_q <= trav_in;
			if (smaller) begin
				cnt_q <= cnt_q + rka_pkg::RANK_W'(1);
			end
		end else if (ctl.shift) begin
			cnt_q <= cnt_in;
		end
	end

	assign trav_out     = trav_q;
	assign trav_vld_out = trav_vld_q;
	assign cnt_out      = cnt_q;

endmodule
`default_nettype wire

/* hw/rtl/rank_assign.sv */
`default_nettype none
// channel | dir | tdata (low bit up)          | tlast      | tuser
// s_axis  | in  | sample[31:0]                 | final_item | -
// m_axis  | out | rank[5:0], zero pad [7:6]    | run_end    | overflow
//
// Loading takes one item per cycle; each item is written into the cell
// chosen by the fill count. On the final item the travelling copies rotate
// round the ring of CAPACITY cells, each cell counting smaller values as
// they pass. The ranks then shift out of cell 0, one per cycle while
// m_tready is high. Input is stalled during ranking and drain.
// Reset (arst_n) empties the store; no clearing pass is needed.
module rank_assign #(
	parameter int CAPACITY = rka_pkg::CAPACITY_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [31:0] s_tdata,   // sample[31:0]
	input  wire        s_tlast,
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // rank[5:0], zero [7:6]
	output logic       m_tlast,
	output logic       m_tuser    // overflow
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_RANK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]         state_q;
	rka_pkg::cnt_t      item_cnt_q;
	rka_pkg::cnt_t      step_q;
	rka_pkg::cnt_t      left_q;
	logic               drop_q;
	logic               out_vld_q;
	rka_pkg::rank_t     out_rank_q;
	logic               out_last_q;
	logic               out_ovf_q;
	rka_pkg::cell_ctl_t ctl;
	logic               in_fire;
	logic               has_room;
	logic               adv;

	rka_pkg::sample_t   trav   [CAPACITY];
	logic               trav_v [CAPACITY];
	rka_pkg::rank_t     cnt    [CAPACITY];

	assign s_tready = (state_q == ST_LOAD);
	assign in_fire  = s_tvalid && s_tready;
	assign has_room = (item_cnt_q < rka_pkg::CNT_W'(CAPACITY));
	assign adv      = (state_q == ST_DRAIN) && (!out_vld_q || m_tready);

	always_comb begin
		ctl.wr     = in_fire && has_room;
		ctl.wr_idx = item_cnt_q;
		ctl.rank   = (state_q == ST_RANK);
		ctl.shift  = adv;
		ctl.clear  = adv && (left_q == rka_pkg::CNT_W'(1));
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			rka_pkg::sample_t t_in;
			logic             tv_in;
			rka_pkg::rank_t   c_in;
			if (g == 0) begin : g_wrap
				assign t_in  = trav[CAPACITY-1];
				assign tv_in = trav_v[CAPACITY-1];
			end else begin : g_link
				assign t_in  = trav[g-1];
				assign tv_in = trav_v[g-1];
			end
			if (g == CAPACITY-1) begin : g_end
				assign c_in = '0;
			end else begin : g_next
				assign c_in = cnt[g+1];
			end
			rka_cell #(.IDX(g)) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctl          (ctl),
				.sample       (rka_pkg::sample_t'(s_tdata)),
				.trav_in      (t_in),
				.trav_vld_in  (tv_in),
				.cnt_in       (c_in),
				.trav_out     (trav[g]),
				.trav_vld_out (trav_v[g]),
				.cnt_out      (cnt[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			item_cnt_q <= '0;
			step_q     <= '0;
			left_q     <= '0;
			drop_q     <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (has_room) begin
							item_cnt_q <= item_cnt_q + rka_pkg::CNT_W'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_RANK;
							step_q  <= rka_pkg::CNT_W'(CAPACITY - 1);
						end
					end
				end
				ST_RANK: begin
					step_q <= step_q - rka_pkg::CNT_W'(1);
					if (step_q == rka_pkg::CNT_W'(1)) begin
						state_q <= ST_DRAIN;
						left_q  <= item_cnt_q;
					end
				end
				ST_DRAIN: begin
					if (adv) begin
						left_q    <= left_q - rka_pkg::CNT_W'(1);
						if (left_q == rka_pkg::CNT_W'(1)) begin
							state_q    <= ST_LOAD;
							item_cnt_q <= '0;
							drop_q     <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_rank_q <= cnt[0];
			out_last_q <= (left_q == rka_pkg::CNT_W'(1));
			out_ovf_q  <= drop_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_rank_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

endmodule
`default_nettype wire
